// ----- hw/rtl/steering_odometry_integrator_top_defines.svh -----
// Assertion macros used by the top-level RTL file of the odometry integrator.
// Each macro expects clk and rst_n to exist in the module that uses it.
`ifndef STEERING_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH
`define STEERING_ODOMETRY_INTEGRATOR_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SOI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("odometry integrator check failed");
`define SOI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("odometry integrator check failed");
`else
`define SOI_ASSERT_IMP(lbl, ante, cons)
`define SOI_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/soi_pkg.sv -----
package soi_pkg;

    localparam int ANGLE_W = 15;
    localparam int SPEED_W = 14;
    localparam int DT_W    = 16;
    localparam int ACC_W   = 32;
    localparam int VLAT_W  = 16;
    localparam int DB_W    = 14;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_A_W = 2;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 128;
    localparam int KIDX_W  = 4;
    localparam int DIV_W   = 16;

    localparam logic [DB_W-1:0]   DEADBAND_RESET = 14'd82;
    localparam logic [GAIN_W-1:0] YAW_GAIN_RESET = 16'd49275;
    localparam logic [DB_W-1:0]   ANGLE_CLAMP    = 14'd12867;
    localparam logic [31:0]       Q30_ONE        = 32'h4000_0000;

    // Horner step indexes: sine steps first, then cosine steps.
    localparam logic [KIDX_W-1:0] KIDX_SIN_LAST = 4'd3;
    localparam logic [KIDX_W-1:0] KIDX_LAST     = 4'd8;
    localparam logic [KIDX_W-1:0] DIV_LAST      = 4'd15;

    localparam logic [CFG_A_W-1:0] REG_DEADBAND = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_YAW_GAIN = 2'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_X2,
        OP_HMUL,
        OP_RMUL,
        OP_TUPD,
        OP_SMUL,
        OP_NMUL,
        OP_DCHK,
        OP_DIV,
        OP_VLAT,
        OP_AXM,
        OP_AXA,
        OP_AYM,
        OP_AYA,
        OP_AHA
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_X2,
        ST_HMUL,
        ST_RMUL,
        ST_TUPD,
        ST_SMUL,
        ST_NMUL,
        ST_DCHK,
        ST_DIV,
        ST_VLAT,
        ST_AXM,
        ST_AXA,
        ST_AYM,
        ST_AYA,
        ST_AHA,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [KIDX_W-1:0] kidx;
    } dp_cmd_t;

    typedef struct packed {
        logic dead;
    } dp_status_t;

    // Divisor of each Horner step.
    function automatic logic [7:0] horner_k(input logic [KIDX_W-1:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:    k = 8'd72;
            4'd1:    k = 8'd42;
            4'd2:    k = 8'd20;
            4'd3:    k = 8'd6;
            4'd4:    k = 8'd90;
            4'd5:    k = 8'd56;
            4'd6:    k = 8'd30;
            4'd7:    k = 8'd12;
            4'd8:    k = 8'd2;
            default: k = 8'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / k); the quotient estimate is then low by at most one.
    function automatic logic [31:0] horner_recip(input logic [KIDX_W-1:0] idx);
        logic [31:0] r;
        case (idx)
            4'd0:    r = 32'd59652323;
            4'd1:    r = 32'd102261126;
            4'd2:    r = 32'd214748364;
            4'd3:    r = 32'd715827882;
            4'd4:    r = 32'd47721858;
            4'd5:    r = 32'd76695844;
            4'd6:    r = 32'd143165576;
            4'd7:    r = 32'd357913941;
            4'd8:    r = 32'd2147483648;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/soi_datapath.sv -----
module soi_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  soi_pkg::dp_cmd_t               cmd,
    output soi_pkg::dp_status_t            status,
    input  logic signed [14:0]             steer_angle,
    input  logic signed [13:0]             left_speed,
    input  logic signed [13:0]             right_speed,
    input  logic [15:0]                    elapsed,
    input  logic                           cfg_wr_en,
    input  logic [soi_pkg::CFG_A_W-1:0]    cfg_addr,
    input  logic [soi_pkg::CFG_W-1:0]      cfg_wdata,
    output logic signed [31:0]             pos_x,
    output logic signed [31:0]             pos_y,
    output logic signed [31:0]             heading,
    output logic signed [13:0]             vel_long,
    output logic signed [15:0]             vel_lat
);
    import soi_pkg::*;

    logic [DB_W-1:0]   deadband_reg;
    logic [GAIN_W-1:0] yaw_gain_reg;

    logic        dead_reg;
    logic        angle_neg_reg;
    logic [13:0] vlong_reg;
    logic [15:0] dt_reg;
    logic [30:0] x_reg;
    logic [31:0] x2_reg;
    logic [30:0] t_reg;
    logic [31:0] p_reg;
    logic [31:0] q_reg;
    logic [30:0] s_reg;
    logic [30:0] c_reg;
    logic [55:0] prod_reg;
    logic [29:0] rem_reg;
    logic [15:0] num_lo_reg;
    logic [15:0] quo_reg;
    logic        ovf_reg;
    logic [15:0] vlat_reg;
    logic [31:0] acc_x_reg;
    logic [31:0] acc_y_reg;
    logic [31:0] acc_h_reg;

    // Input conditioning for the load step.
    logic [14:0] speed_sum;
    logic [14:0] angle_mag;
    logic [13:0] angle_clamped;
    logic        dead_in;

    assign speed_sum     = {left_speed[13], left_speed} + {right_speed[13], right_speed};
    assign angle_mag     = steer_angle[14] ? (~steer_angle + 15'd1) : steer_angle;
    assign dead_in       = (angle_mag <= {1'b0, deadband_reg});
    assign angle_clamped = (angle_mag > {1'b0, ANGLE_CLAMP}) ? ANGLE_CLAMP : angle_mag[13:0];

    // Shared signed multiplier; unsigned operands are zero extended.
    logic [13:0]        vmag;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod;

    assign vmag = vlong_reg[13] ? (~vlong_reg + 14'd1) : vlong_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_X2:
            begin
                mul_a = {2'b00, x_reg};
                mul_b = {2'b00, x_reg};
            end
            OP_HMUL:
            begin
                mul_a = {1'b0, x2_reg};
                mul_b = {2'b00, t_reg};
            end
            OP_RMUL:
            begin
                mul_a = {1'b0, p_reg};
                mul_b = {1'b0, horner_recip(cmd.kidx)};
            end
            OP_SMUL:
            begin
                mul_a = {2'b00, x_reg};
                mul_b = {2'b00, t_reg};
            end
            OP_NMUL:
            begin
                mul_a = {19'd0, vmag};
                mul_b = {2'b00, s_reg};
            end
            OP_AXM:
            begin
                mul_a = {{19{vlong_reg[13]}}, vlong_reg};
                mul_b = {17'd0, dt_reg};
            end
            OP_AYM:
            begin
                mul_a = {{17{vlat_reg[15]}}, vlat_reg};
                mul_b = {17'd0, dt_reg};
            end
            OP_AYA:
            begin
                mul_a = prod_reg[32:0];
                mul_b = {17'd0, yaw_gain_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Horner step correction: the reciprocal estimate may be one short.
    logic [7:0]  kval;
    logic [15:0] kq_full;
    logic [7:0]  rmd;
    logic        fix;
    logic [31:0] qq;
    logic [31:0] t_new;

    assign kval    = horner_k(cmd.kidx);
    assign kq_full = q_reg[7:0] * kval;
    assign rmd     = p_reg[7:0] - kq_full[7:0];
    assign fix     = (rmd >= kval);
    assign qq      = q_reg + {31'd0, fix};
    assign t_new   = Q30_ONE - qq;

    // One restoring division step.
    logic [30:0] rem2;
    logic        div_ge;
    logic [30:0] rem_sub;

    assign rem2    = {rem_reg, num_lo_reg[15]};
    assign div_ge  = (rem2 >= c_reg);
    assign rem_sub = rem2 - c_reg;

    // Saturated lateral speed.
    logic        lat_neg;
    logic [16:0] mag17;
    logic [16:0] mag_sat;
    logic [16:0] mag_neg;

    assign lat_neg = vlong_reg[13] ^ angle_neg_reg;
    assign mag17   = {1'b0, quo_reg};

    always_comb
    begin
        if (lat_neg)
        begin
            mag_sat = (ovf_reg || (mag17 > 17'd32768)) ? 17'd32768 : mag17;
        end
        else
        begin
            mag_sat = (ovf_reg || (mag17 > 17'd32767)) ? 17'd32767 : mag17;
        end
    end

    assign mag_neg = 17'd0 - mag_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg <= DEADBAND_RESET;
            yaw_gain_reg <= YAW_GAIN_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_DEADBAND: deadband_reg <= cfg_wdata[DB_W-1:0];
                REG_YAW_GAIN: yaw_gain_reg <= cfg_wdata[GAIN_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg  <= 1'b0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_h_reg <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD: dead_reg  <= dead_in;
                OP_AXA:  acc_x_reg <= acc_x_reg + prod_reg[39:8];
                OP_AYA:  acc_y_reg <= acc_y_reg + prod_reg[39:8];
                OP_AHA:  acc_h_reg <= acc_h_reg + prod_reg[55:24];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                vlong_reg     <= speed_sum[14:1];
                dt_reg        <= elapsed;
                angle_neg_reg <= steer_angle[14];
                x_reg         <= {angle_clamped, 17'd0};
                vlat_reg      <= '0;
            end
            OP_X2:
            begin
                x2_reg <= prod[61:30];
                t_reg  <= Q30_ONE[30:0];
            end
            OP_HMUL: p_reg <= prod[61:30];
            OP_RMUL: q_reg <= prod[63:32];
            OP_TUPD:
            begin
                if (cmd.kidx == KIDX_LAST)
                begin
                    c_reg <= (qq >= Q30_ONE) ? 31'd1 : t_new[30:0];
                end
                else
                begin
                    t_reg <= t_new[30:0];
                end
            end
            OP_SMUL:
            begin
                s_reg <= prod[60:30];
                t_reg <= Q30_ONE[30:0];
            end
            OP_NMUL: prod_reg <= prod[55:0];
            OP_DCHK:
            begin
                ovf_reg    <= ({2'b00, prod_reg[44:16]} >= c_reg);
                rem_reg    <= {1'b0, prod_reg[44:16]};
                num_lo_reg <= prod_reg[15:0];
                quo_reg    <= '0;
            end
            OP_DIV:
            begin
                rem_reg    <= div_ge ? rem_sub[29:0] : rem2[29:0];
                quo_reg    <= {quo_reg[14:0], div_ge};
                num_lo_reg <= {num_lo_reg[14:0], 1'b0};
            end
            OP_VLAT: vlat_reg <= lat_neg ? mag_neg[15:0] : mag_sat[15:0];
            OP_AXM:  prod_reg <= prod[55:0];
            OP_AYM:  prod_reg <= prod[55:0];
            OP_AYA:  prod_reg <= prod[55:0];
            default: ;
        endcase
    end

    assign status.dead = dead_reg;

    assign pos_x    = acc_x_reg;
    assign pos_y    = acc_y_reg;
    assign heading  = acc_h_reg;
    assign vel_long = vlong_reg;
    assign vel_lat  = vlat_reg;

endmodule

// ----- hw/rtl/soi_ctrl.sv -----
module soi_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_slot_free,
    output logic                out_load,
    output soi_pkg::dp_cmd_t    cmd,
    input  soi_pkg::dp_status_t status
);
    import soi_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    logic [KIDX_W-1:0] kidx_reg;
    logic [KIDX_W-1:0] kidx_next;
    logic [3:0]        div_cnt_reg;
    logic [3:0]        div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kidx_reg    <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            kidx_reg    <= kidx_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        kidx_next    = kidx_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = OP_NONE;
        cmd.kidx     = kidx_reg;
        in_ready     = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_X2;
                end
            end
            ST_X2:
            begin
                cmd.op     = OP_X2;
                kidx_next  = '0;
                state_next = status.dead ? ST_AXM : ST_HMUL;
            end
            ST_HMUL:
            begin
                cmd.op     = OP_HMUL;
                state_next = ST_RMUL;
            end
            ST_RMUL:
            begin
                cmd.op     = OP_RMUL;
                state_next = ST_TUPD;
            end
            ST_TUPD:
            begin
                cmd.op    = OP_TUPD;
                kidx_next = kidx_reg + 4'd1;
                if (kidx_reg == KIDX_SIN_LAST)
                begin
                    state_next = ST_SMUL;
                end
                else if (kidx_reg == KIDX_LAST)
                begin
                    state_next = ST_NMUL;
                end
                else
                begin
                    state_next = ST_HMUL;
                end
            end
            ST_SMUL:
            begin
                cmd.op     = OP_SMUL;
                state_next = ST_HMUL;
            end
            ST_NMUL:
            begin
                cmd.op     = OP_NMUL;
                state_next = ST_DCHK;
            end
            ST_DCHK:
            begin
                cmd.op       = OP_DCHK;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = ST_VLAT;
                end
            end
            ST_VLAT:
            begin
                cmd.op     = OP_VLAT;
                state_next = ST_AXM;
            end
            ST_AXM:
            begin
                cmd.op     = OP_AXM;
                state_next = ST_AXA;
            end
            ST_AXA:
            begin
                cmd.op     = OP_AXA;
                state_next = ST_AYM;
            end
            ST_AYM:
            begin
                cmd.op     = OP_AYM;
                state_next = ST_AYA;
            end
            ST_AYA:
            begin
                cmd.op     = OP_AYA;
                state_next = ST_AHA;
            end
            ST_AHA:
            begin
                cmd.op     = OP_AHA;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_slot_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/steering_odometry_integrator_top.sv -----
// Sequence: each accepted beat runs the X2 step, the nine Horner steps on the shared multiplier, the
// sixteen-step restoring divider and the accumulate steps; inside the deadband the tangent and
// division work is skipped. A new input beat is taken only after the previous result has been
// loaded into the output register, and that load can wait on the downstream side.
// Reset: rst_n clears the accumulators and the output valid flag and restores register defaults.
`include "steering_odometry_integrator_top_defines.svh"

module steering_odometry_integrator_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // s_axis_tdata, low bit up: steer_angle[14:0], left_speed[28:15],
    // right_speed[42:29], elapsed[58:43], zero fill[63:59]
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [soi_pkg::IN_W-1:0]    s_axis_tdata,
    // m_axis_tdata, low bit up: pos_x[31:0], pos_y[63:32], heading[95:64],
    // vel_long[109:96], vel_lat[125:110], zero fill[127:126]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [soi_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_wr_en,
    input  logic [soi_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [soi_pkg::CFG_W-1:0]   cfg_wdata
);
    import soi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       out_load;
    logic       out_slot_free;

    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [13:0] vel_long;
    logic signed [15:0] vel_lat;

    // The result register frees the controller as soon as the downstream side
    // takes the beat, so the next item can be accepted while a result waits.
    assign out_slot_free = !out_valid_reg || m_axis_tready;

    soi_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .out_slot_free (out_slot_free),
        .out_load      (out_load),
        .cmd           (cmd),
        .status        (status)
    );

    soi_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .steer_angle (s_axis_tdata[14:0]),
        .left_speed  (s_axis_tdata[28:15]),
        .right_speed (s_axis_tdata[42:29]),
        .elapsed     (s_axis_tdata[58:43]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .heading     (heading),
        .vel_long    (vel_long),
        .vel_lat     (vel_lat)
    );

    // Output beat register. The valid flag is control state; the data is not reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {2'b00, vel_lat, vel_long, heading, pos_y, pos_x};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A new result never overwrites one the downstream side has not taken.
    `SOI_ASSERT_IMP(a_no_overwrite, out_load, !out_valid_reg || m_axis_tready)
    // Once a beat is accepted the block works on it and takes no further beat.
    `SOI_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A finished result is presented on the next cycle.
    `SOI_ASSERT_NXT(a_result_shown, out_load, m_axis_tvalid)

endmodule
